FILE: rtl/core/greedy_box_nms_top_defines.svh
// assertion macros used by the checker file
`ifndef GREEDY_BOX_NMS_TOP_DEFINES_SVH
`define GREEDY_BOX_NMS_TOP_DEFINES_SVH

// same-cycle implication under the block reset
`define GNMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under the block reset
`define GNMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/gnms_pkg.sv
// shared types and constants of the greedy box nms block
`timescale 1ns / 1ps
package gnms_pkg;
	localparam int MAX_BOXES_DEF = 64;
	localparam int IDX_W = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam logic [16:0] LIMIT_ONE = 17'd65536;
	localparam logic [16:0] LIMIT_FLOOR = 17'd6554;
	localparam logic [16:0] DECAY_OFF = 17'd65536;
	localparam logic [16:0] OVERLAP_RST = 17'd32768;

	typedef enum logic [1:0] {
		CFG_SCORE_THR = 2'd0,
		CFG_OVERLAP_THR = 2'd1,
		CFG_DECAY = 2'd2,
		CFG_KEEP_LIMIT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] box_x;
		logic signed [15:0] box_y;
		logic [14:0] box_width;
		logic [14:0] box_height;
		logic [15:0] box_score;
		logic batch_end;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0] kept_index;
		logic none_kept;
		logic overflowed;
		logic run_end;
	} out_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0] w;
		logic [14:0] h;
	} rect_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		rect_t rect;
		logic [15:0] score;
		logic store;
		logic cand;
		logic last;
		logic ovf;
	} beat_t;
endpackage

FILE: rtl/core/gnms_front.sv
// front end: takes boxes, numbers and classifies them, flags overflow
`timescale 1ns / 1ps
module gnms_front #(
	parameter int MAX_BOXES = gnms_pkg::MAX_BOXES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  gnms_pkg::in_t box,
	input  logic [15:0] score_thr,
	input  logic q_full,
	input  logic batch_done,
	output logic push,
	output gnms_pkg::beat_t push_beat
);
	import gnms_pkg::*;
	localparam int CW = $clog2(MAX_BOXES + 1);

	logic [CW-1:0] box_cnt_q;
	logic ovf_q;
	logic hold_q;
	logic accept;
	logic store;

	assign busy = hold_q | q_full;
	assign accept = start & ~busy;
	assign store = box_cnt_q < CW'(MAX_BOXES);
	assign push = accept & (store | box.batch_end);

	always_comb begin
		push_beat.idx = IDX_W'(box_cnt_q);
		push_beat.rect.x = box.box_x;
		push_beat.rect.y = box.box_y;
		push_beat.rect.w = box.box_width;
		push_beat.rect.h = box.box_height;
		push_beat.score = box.box_score;
		push_beat.store = store;
		push_beat.cand = box.box_score > score_thr;
		push_beat.last = box.batch_end;
		push_beat.ovf = ovf_q | ~store;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_cnt_q <= '0;
			ovf_q <= 1'b0;
			hold_q <= 1'b0;
		end else begin
			if (batch_done) hold_q <= 1'b0;
			if (accept) begin
				if (box.batch_end) begin
					box_cnt_q <= '0;
					ovf_q <= 1'b0;
					hold_q <= 1'b1;
				end else if (store) begin
					box_cnt_q <= box_cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end
endmodule

FILE: rtl/core/gnms_queue.sv
// short fifo of box beats between front and back
`timescale 1ns / 1ps
module gnms_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  gnms_pkg::beat_t push_beat,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output gnms_pkg::beat_t pop_beat
);
	import gnms_pkg::*;
	localparam int PW = $clog2(QUEUE_DEPTH);

	beat_t slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] cnt_q;
	logic do_push, do_pop;

	assign full = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_beat = slot_q[rd_q];
	assign do_push = push & ~full;
	assign do_pop = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

FILE: rtl/core/gnms_back.sv
// back end: sorting cells, pairwise overlap test, kept list and result output
`timescale 1ns / 1ps
module gnms_back #(
	parameter int MAX_BOXES = gnms_pkg::MAX_BOXES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	input  gnms_pkg::beat_t pop_beat,
	output logic pop,
	input  logic [16:0] overlap_thr,
	input  logic [16:0] decay,
	input  logic [6:0] keep_limit,
	output logic batch_done,
	output logic result_valid,
	output gnms_pkg::out_t result
);
	import gnms_pkg::*;
	localparam int AW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);

	typedef enum logic [9:0] {
		ST_LOAD  = 10'b0000000001,
		ST_PREP  = 10'b0000000010,
		ST_CAND  = 10'b0000000100,
		ST_PAIR  = 10'b0000001000,
		ST_G1    = 10'b0000010000,
		ST_G2    = 10'b0000100000,
		ST_G3    = 10'b0001000000,
		ST_CMP   = 10'b0010000000,
		ST_EREAD = 10'b0100000000,
		ST_EOUT  = 10'b1000000000
	} state_t;

	state_t state_q;

	// sorted cells, descending score, stable
	logic [15:0] cell_score_q [MAX_BOXES];
	logic [AW-1:0] cell_idx_q [MAX_BOXES];
	logic cell_vld_q [MAX_BOXES];
	logic gt [MAX_BOXES];

	rect_t box_mem [MAX_BOXES];
	rect_t kept_box_mem [MAX_BOXES];
	logic [AW-1:0] kept_idx_mem [MAX_BOXES];

	rect_t cand_box_q, kept_rd_q;
	logic [AW-1:0] cand_idx_q, emit_idx_q;
	logic [CW-1:0] cand_cnt_q, n_q, i_q, kept_q, k_q, emit_q;
	logic [16:0] limit_q;
	logic ovf_q;

	logic signed [17:0] dw_q, dh_q;
	logic [29:0] area_a_q, area_b_q, inter_q;
	logic [30:0] area_sum_q;
	logic zero_q;
	logic [47:0] prod_q;

	logic insert;
	logic keep_now;
	logic pair_ok;
	logic last_emit;
	logic [33:0] decay_prod;
	logic signed [17:0] a_x0, b_x0, a_y0, b_y0, a_x1, b_x1, a_y1, b_y1;
	logic signed [17:0] lo_x, lo_y, hi_x, hi_y;

	assign pop = state_q == ST_LOAD;
	assign insert = pop & pop_valid & pop_beat.store & pop_beat.cand;
	assign keep_now = (state_q == ST_PAIR) && (k_q == kept_q);
	assign decay_prod = limit_q * decay;
	assign last_emit = (kept_q == '0) || (emit_q + 1'b1 == kept_q);
	assign batch_done = (state_q == ST_EOUT) && last_emit;

	always_comb begin
		for (int c = 0; c < MAX_BOXES; c++)
			gt[c] = ~cell_vld_q[c] | (pop_beat.score > cell_score_q[c]);
	end

	// overlap geometry of candidate against one kept box
	always_comb begin
		a_x0 = 18'(cand_box_q.x);
		a_y0 = 18'(cand_box_q.y);
		b_x0 = 18'(kept_rd_q.x);
		b_y0 = 18'(kept_rd_q.y);
		a_x1 = a_x0 + 18'($signed({1'b0, cand_box_q.w}));
		a_y1 = a_y0 + 18'($signed({1'b0, cand_box_q.h}));
		b_x1 = b_x0 + 18'($signed({1'b0, kept_rd_q.w}));
		b_y1 = b_y0 + 18'($signed({1'b0, kept_rd_q.h}));
		lo_x = (a_x0 > b_x0) ? a_x0 : b_x0;
		lo_y = (a_y0 > b_y0) ? a_y0 : b_y0;
		hi_x = (a_x1 < b_x1) ? a_x1 : b_x1;
		hi_y = (a_y1 < b_y1) ? a_y1 : b_y1;
		pair_ok = zero_q ? (limit_q >= LIMIT_ONE) : ({2'b0, inter_q, 16'b0} <= prod_q);
	end

	always_ff @(posedge clk) begin
		if (pop & pop_valid & pop_beat.store)
			box_mem[pop_beat.idx[AW-1:0]] <= pop_beat.rect;
		if (state_q == ST_CAND) begin
			cand_box_q <= box_mem[cell_idx_q[0]];
			cand_idx_q <= cell_idx_q[0];
		end
		if (state_q == ST_PAIR) kept_rd_q <= kept_box_mem[k_q[AW-1:0]];
		if (keep_now) begin
			kept_box_mem[kept_q[AW-1:0]] <= cand_box_q;
			kept_idx_mem[kept_q[AW-1:0]] <= cand_idx_q;
		end
		if (state_q == ST_EREAD) emit_idx_q <= kept_idx_mem[emit_q[AW-1:0]];
		if (state_q == ST_G1) begin
			dw_q <= hi_x - lo_x;
			dh_q <= hi_y - lo_y;
			area_a_q <= cand_box_q.w * cand_box_q.h;
			area_b_q <= kept_rd_q.w * kept_rd_q.h;
		end
		if (state_q == ST_G2) begin
			inter_q <= (dw_q > 0 && dh_q > 0) ? dw_q[14:0] * dh_q[14:0] : 30'd0;
			area_sum_q <= {1'b0, area_a_q} + {1'b0, area_b_q};
			zero_q <= (area_a_q == '0) && (area_b_q == '0);
		end
		if (state_q == ST_G3)
			prod_q <= limit_q * (area_sum_q - {1'b0, inter_q});
		for (int c = 0; c < MAX_BOXES; c++) begin
			if (insert && gt[c]) begin
				if (c > 0 && gt[c-1]) begin
					cell_score_q[c] <= cell_score_q[c-1];
					cell_idx_q[c] <= cell_idx_q[c-1];
				end else begin
					cell_score_q[c] <= pop_beat.score;
					cell_idx_q[c] <= pop_beat.idx[AW-1:0];
				end
			end else if (state_q == ST_CAND && i_q != n_q && c < MAX_BOXES - 1) begin
				cell_score_q[c] <= cell_score_q[c+1];
				cell_idx_q[c] <= cell_idx_q[c+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			for (int c = 0; c < MAX_BOXES; c++) cell_vld_q[c] <= 1'b0;
			cand_cnt_q <= '0;
			n_q <= '0;
			i_q <= '0;
			kept_q <= '0;
			k_q <= '0;
			emit_q <= '0;
			limit_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (insert) begin
						for (int c = 0; c < MAX_BOXES; c++)
							if (gt[c] && (c == 0 || cell_vld_q[c-1]))
								cell_vld_q[c] <= 1'b1;
						cand_cnt_q <= cand_cnt_q + 1'b1;
					end
					if (pop_valid && pop_beat.last) begin
						ovf_q <= pop_beat.ovf;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					n_q <= (keep_limit != '0 && keep_limit < 7'(cand_cnt_q)) ?
						CW'(keep_limit) : cand_cnt_q;
					limit_q <= overlap_thr;
					kept_q <= '0;
					i_q <= '0;
					emit_q <= '0;
					state_q <= ST_CAND;
				end
				ST_CAND: begin
					if (i_q == n_q) begin
						state_q <= ST_EREAD;
					end else begin
						for (int c = 0; c < MAX_BOXES; c++)
							cell_vld_q[c] <= (c < MAX_BOXES - 1) ? cell_vld_q[c+1] : 1'b0;
						i_q <= i_q + 1'b1;
						k_q <= '0;
						state_q <= ST_PAIR;
					end
				end
				ST_PAIR: begin
					if (keep_now) begin
						kept_q <= kept_q + 1'b1;
						if (decay < DECAY_OFF && limit_q >= LIMIT_FLOOR)
							limit_q <= decay_prod[32:16];
						state_q <= ST_CAND;
					end else begin
						state_q <= ST_G1;
					end
				end
				ST_G1: state_q <= ST_G2;
				ST_G2: state_q <= ST_G3;
				ST_G3: state_q <= ST_CMP;
				ST_CMP: begin
					if (pair_ok) begin
						k_q <= k_q + 1'b1;
						state_q <= ST_PAIR;
					end else begin
						state_q <= ST_CAND;
					end
				end
				ST_EREAD: state_q <= ST_EOUT;
				ST_EOUT: begin
					emit_q <= emit_q + 1'b1;
					if (last_emit) begin
						for (int c = 0; c < MAX_BOXES; c++) cell_vld_q[c] <= 1'b0;
						cand_cnt_q <= '0;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_EREAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign result_valid = state_q == ST_EOUT;
	always_comb begin
		result.kept_index = (kept_q == '0) ? '0 : IDX_W'(emit_idx_q);
		result.none_kept = kept_q == '0;
		result.overflowed = ovf_q;
		result.run_end = last_emit;
	end
endmodule

FILE: rtl/core/greedy_box_nms_top.sv
// top level of the greedy box nms block
`timescale 1ns / 1ps
// greedy non-maximum suppression of rectangles by iou
// box channel: a box beat is taken at a clock edge with start high and busy low;
//   boxes load one per cycle while busy is low, batch_end marks the last box of a batch
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
//   write only while the block is idle
// result channel: result_valid is high for one cycle per kept box, in keep order;
//   run_end marks the last one, none_kept a batch with no survivor
// sequence: the last box passes the queue registers, then the ST_PREP setup state,
//   then each candidate takes ST_CAND plus ST_PAIR, ST_G1, ST_G2, ST_G3 and ST_CMP
//   per kept box it is tested against (one shared overlap datapath), a keep adds
//   ST_PAIR, a final ST_CAND closes the walk, and each result takes ST_EREAD, ST_EOUT
// busy stays high from the last box until the final result goes out
// boxes past MAX_BOXES are dropped and reported through overflowed
// the receiver cannot stall; results are never held back
// reset: config returns to its defaults (overlap 0.5, no decay, no top-k),
//   counters, queue and sorting cells clear, memories are not cleared
module greedy_box_nms_top #(
	parameter int MAX_BOXES = gnms_pkg::MAX_BOXES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  gnms_pkg::in_t box,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [16:0] cfg_data,
	output logic result_valid,
	output gnms_pkg::out_t result
);
	import gnms_pkg::*;

	// configuration registers
	logic [15:0] score_thr_q;
	logic [16:0] overlap_thr_q;
	logic [16:0] decay_q;
	logic [6:0] keep_limit_q;

	// front to queue to back
	logic push, q_full, pop, pop_valid, batch_done;
	beat_t push_beat, pop_beat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_thr_q <= '0;
			overlap_thr_q <= OVERLAP_RST;
			decay_q <= DECAY_OFF;
			keep_limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SCORE_THR: score_thr_q <= cfg_data[15:0];
				CFG_OVERLAP_THR: overlap_thr_q <= cfg_data;
				CFG_DECAY: decay_q <= cfg_data;
				CFG_KEEP_LIMIT: keep_limit_q <= cfg_data[6:0];
				default: score_thr_q <= score_thr_q;
			endcase
		end
	end

	// numbering, candidate test and overflow tracking
	gnms_front #(.MAX_BOXES(MAX_BOXES)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .box(box),
		.score_thr(score_thr_q), .q_full(q_full), .batch_done(batch_done),
		.push(push), .push_beat(push_beat)
	);

	gnms_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_beat(push_beat), .full(q_full),
		.pop(pop), .pop_valid(pop_valid), .pop_beat(pop_beat)
	);

	// sorting, suppression and result emission
	gnms_back #(.MAX_BOXES(MAX_BOXES)) u_back (
		.clk(clk), .arst_n(arst_n), .pop_valid(pop_valid), .pop_beat(pop_beat),
		.pop(pop), .overlap_thr(overlap_thr_q), .decay(decay_q),
		.keep_limit(keep_limit_q), .batch_done(batch_done),
		.result_valid(result_valid), .result(result)
	);
endmodule

FILE: rtl/core/gnms_checker.sv
// port-level checks of the greedy box nms block and their bind
`timescale 1ns / 1ps
`include "greedy_box_nms_top_defines.svh"
module gnms_checker (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic result_valid,
	input gnms_pkg::out_t result
);
	`GNMS_ASSERT_NOW(a_empty_ends, result_valid && result.none_kept, result.run_end, "empty result not last")
	`GNMS_ASSERT_NOW(a_empty_idx, result_valid && result.none_kept, result.kept_index == '0, "empty result index set")
	`GNMS_ASSERT_NEXT(a_gap, result_valid, !result_valid, "results back to back")
	`GNMS_ASSERT_NOW(a_busy_out, result_valid && !result.run_end, busy, "not busy mid run")
endmodule

bind greedy_box_nms_top gnms_checker u_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .result_valid(result_valid), .result(result)
);
